// File: rtl/hdlm_pkg.sv
// ----------------------------------------------------------------------------
// hdlm_pkg
// Shared types, codes and helpers of the here-document delimiter line matcher.
// ----------------------------------------------------------------------------
package hdlm_pkg;

  // default delimiter capacity in bytes
  localparam int MAX_DELIM_DEFAULT = 32;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // byte codes the front classifies
  localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // input kind codes
  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_BODY  = 2'd0;
  localparam logic [1:0] STATUS_DELIM = 2'd1;
  localparam logic [1:0] STATUS_UNTERM = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_DELIM_WORD0 = 3'd0;
  localparam logic [2:0] REG_DELIM_WORD1 = 3'd1;
  localparam logic [2:0] REG_DELIM_WORD2 = 3'd2;
  localparam logic [2:0] REG_DELIM_WORD3 = 3'd3;
  localparam logic [2:0] REG_DELIM_LENGTH = 3'd4;
  localparam logic [2:0] REG_TAB_STRIP   = 3'd5;
  localparam logic [2:0] REG_DELIM_QUOTED = 3'd6;

  // classified input item
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       is_newline;
    logic       is_tab;
    logic       is_bslash;
  } item_t;

  // configuration write
  typedef struct packed {
    logic        valid;
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

  // saturating 16-bit add
  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// File: rtl/hdlm_front.sv
// ----------------------------------------------------------------------------
// hdlm_front
// Accepts input items and classifies each byte before it enters the queue.
// ----------------------------------------------------------------------------
module hdlm_front import hdlm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tuser,   // kind
  output logic       push,
  output item_t      push_item,
  input  logic       push_ready
);

  logic  held;
  item_t item;

  assign s_tready  = !held || push_ready;
  assign push      = held && push_ready;
  assign push_item = item;

  // holding register with byte classification
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      item.kind       <= s_tuser;
      item.data_byte  <= s_tdata;
      item.is_newline <= (s_tdata == CHAR_NEWLINE);
      item.is_tab     <= (s_tdata == CHAR_TAB);
      item.is_bslash  <= (s_tdata == CHAR_BSLASH);
    end
  end

endmodule

// File: rtl/hdlm_queue.sv
// ----------------------------------------------------------------------------
// hdlm_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module hdlm_queue import hdlm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  push_ready,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// File: rtl/hdlm_back.sv
// ----------------------------------------------------------------------------
// hdlm_back
// Line engine: joining, tab stripping, delimiter compare and result register.
// ----------------------------------------------------------------------------
module hdlm_back import hdlm_pkg::*; #(
  parameter int MAX_DELIM = MAX_DELIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_wr_t     cfg_wr,
  input  logic        pop_valid,
  input  item_t       pop_item,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // candidate_bytes
  output logic [1:0]  m_tuser    // status
);

  localparam int         IDX_W   = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam logic [5:0] MAX_LEN = 6'(MAX_DELIM);

  // configuration
  logic [MAX_DELIM-1:0][7:0] delim;
  logic [5:0]                delim_length;
  logic                      tab_strip;
  logic                      delim_quoted;

  // line state
  logic [5:0]  logical_pos,    logical_pos_next;
  logic        mismatch_valid, mismatch_valid_next;
  logic [5:0]  mismatch_pos,   mismatch_pos_next;
  logic        backslash_odd,  backslash_odd_next;
  logic        in_leading_tabs, in_leading_tabs_next;
  logic [15:0] physical_count, physical_count_next;
  logic [15:0] group_count,    group_count_next;

  logic        res_valid;
  logic [1:0]  res_status;
  logic [15:0] res_count;

  logic [5:0]  eff_len;
  logic        line_match;
  logic [15:0] phys_inc;
  logic [5:0]  pos_dec;
  logic [7:0]  delim_at_pos;

  // delimiter byte registers, only bytes below capacity are kept
  always_ff @(posedge clk) begin
    if (rst) begin
      delim <= '0;
    end else if (cfg_wr.valid) begin
      for (int k = 0; k < MAX_DELIM; k++) begin
        if (cfg_wr.index == 3'(k >> 3)) delim[k] <= cfg_wr.data[8 * (k & 7) +: 8];
      end
    end
  end

  // scalar configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_length <= '0;
      tab_strip    <= 1'b0;
      delim_quoted <= 1'b0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_DELIM_LENGTH: delim_length <= cfg_wr.data[5:0];
        REG_TAB_STRIP:    tab_strip    <= cfg_wr.data[0];
        REG_DELIM_QUOTED: delim_quoted <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  assign pop          = pop_valid && (!m_tvalid || m_tready);
  assign eff_len      = (delim_length > MAX_LEN) ? MAX_LEN : delim_length;
  assign line_match   = !mismatch_valid && (logical_pos == eff_len);
  assign phys_inc     = sat_add16(physical_count, 16'd1);
  assign pos_dec      = (logical_pos != '0) ? logical_pos - 6'd1 : logical_pos;
  assign delim_at_pos = delim[logical_pos[IDX_W-1:0]];

  // next line state and result of the popped item
  always_comb begin
    logical_pos_next     = logical_pos;
    mismatch_valid_next  = mismatch_valid;
    mismatch_pos_next    = mismatch_pos;
    backslash_odd_next   = backslash_odd;
    in_leading_tabs_next = in_leading_tabs;
    physical_count_next  = physical_count;
    group_count_next     = group_count;
    res_valid            = 1'b0;
    res_status           = STATUS_BODY;
    res_count            = sat_add16(group_count, physical_count);

    if (pop_item.kind == KIND_END) begin
      // end of input closes any pending group
      res_valid  = 1'b1;
      res_status = (physical_count != '0 && line_match) ? STATUS_DELIM : STATUS_UNTERM;
    end else if (pop_item.is_newline) begin
      if (!delim_quoted && backslash_odd) begin
        // continuation: drop the last backslash and undo its compare
        logical_pos_next = pos_dec;
        if (mismatch_valid && mismatch_pos == pos_dec) mismatch_valid_next = 1'b0;
        group_count_next     = sat_add16(group_count, phys_inc);
        physical_count_next  = '0;
        backslash_odd_next   = 1'b0;
        in_leading_tabs_next = (pos_dec == '0);
      end else begin
        res_valid  = 1'b1;
        res_status = line_match ? STATUS_DELIM : STATUS_BODY;
        res_count  = sat_add16(group_count, phys_inc);
      end
    end else begin
      physical_count_next = phys_inc;
      if (!(in_leading_tabs && pop_item.is_tab && tab_strip)) begin
        in_leading_tabs_next = 1'b0;
        if (!mismatch_valid &&
            ((logical_pos >= eff_len) || (pop_item.data_byte != delim_at_pos))) begin
          mismatch_valid_next = 1'b1;
          mismatch_pos_next   = logical_pos;
        end
        if (logical_pos < 6'd63) logical_pos_next = logical_pos + 6'd1;
        backslash_odd_next = pop_item.is_bslash ? !backslash_odd : 1'b0;
      end
    end

    // any result starts a fresh line
    if (res_valid) begin
      logical_pos_next     = '0;
      mismatch_valid_next  = 1'b0;
      mismatch_pos_next    = '0;
      backslash_odd_next   = 1'b0;
      in_leading_tabs_next = 1'b1;
      physical_count_next  = '0;
      group_count_next     = '0;
    end
  end

  // line state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      logical_pos     <= '0;
      mismatch_valid  <= 1'b0;
      mismatch_pos    <= '0;
      backslash_odd   <= 1'b0;
      in_leading_tabs <= 1'b1;
      physical_count  <= '0;
      group_count     <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (pop) begin
        logical_pos     <= logical_pos_next;
        mismatch_valid  <= mismatch_valid_next;
        mismatch_pos    <= mismatch_pos_next;
        backslash_odd   <= backslash_odd_next;
        in_leading_tabs <= in_leading_tabs_next;
        physical_count  <= physical_count_next;
        group_count     <= group_count_next;
      end
      if (pop && res_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (pop && res_valid) begin
      m_tdata <= res_count;
      m_tuser <= res_status;
    end
  end

endmodule

// File: rtl/heredoc_delimiter_line_matcher.sv
// ----------------------------------------------------------------------------
// heredoc_delimiter_line_matcher
// Finds the closing delimiter line of a here-document body, byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one item per byte: tuser is the kind (body byte or end
//   of input), tdata the raw byte. m_* channel gives one item per finished
//   logical line or end of input: tuser the status, tdata the raw byte count
//   of the line group (saturating at 65535).
//   cfg_* writes the delimiter words, length, tab stripping and quoting; it
//   is always ready; the user must write it only while the block is idle,
//   which the block itself does not enforce.
// Path: an item passes the front register, the queue and the back register.
// Throughput: one item per cycle unless m_* stalls, set by the line state
//   update in the back engine; bytes that end no line give no output item.
// Reset: rst clears the configuration to zero, empties the queue and starts
//   a fresh line with leading-tab stripping armed.
// Stall: a held result on m_* stops the back engine; the queue and the front
//   register keep taking items until they fill, then s_tready drops.
// ----------------------------------------------------------------------------
module heredoc_delimiter_line_matcher import hdlm_pkg::*; #(
  parameter int MAX_DELIM = MAX_DELIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // data_byte
  input  logic        s_tuser,    // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // candidate_bytes
  output logic [1:0]  m_tuser,    // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic    push, push_ready, pop, pop_valid;
  item_t   push_item, pop_item;
  cfg_wr_t cfg_wr;

  // configuration writes are taken every cycle
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  hdlm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  hdlm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  hdlm_back #(
    .MAX_DELIM (MAX_DELIM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// File: rtl/hdlm_checker.sv
// ----------------------------------------------------------------------------
// hdlm_checker
// Port-level checks on the result channel of the line matcher.
// ----------------------------------------------------------------------------
module hdlm_checker import hdlm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result payload changed while stalled");

  // no result right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

  // status is one of the three codes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == STATUS_BODY || m_tuser == STATUS_DELIM ||
                  m_tuser == STATUS_UNTERM))
    else $error("unknown status code");

  // a delimiter line always holds at least one raw byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_DELIM |-> m_tdata != 16'd0)
    else $error("delimiter line with empty byte count");

endmodule

bind heredoc_delimiter_line_matcher hdlm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
